// ===== sv/psar_pkg.sv =====
package psar_pkg;

   // Segmentation codes carried in the top two bits of a write's header byte.
   localparam logic [1:0] SEG_COMPLETE = 2'b00;
   localparam logic [1:0] SEG_FIRST    = 2'b01;
   localparam logic [1:0] SEG_MIDDLE   = 2'b10;
   localparam logic [1:0] SEG_LAST     = 2'b11;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       write_start;
      logic       write_end;
   } req_type;

   typedef struct packed {
      logic [7:0] message_byte;
      logic [5:0] byte_position;
      logic       message_end;
      logic       empty_message;
   } rsp_type;

   // Load request from the sequencer into the result register.
   typedef struct packed {
      logic    load;
      rsp_type item;
   } rsp_load_type;

   typedef enum logic [2:0] {
      ST_RECV,
      ST_FINISH,
      ST_COPY_RD,
      ST_COPY_WR,
      ST_COPY_DONE,
      ST_EMIT_RD,
      ST_EMIT_LD,
      ST_EMPTY
   } state_type;

endpackage

// ===== sv/psar_ram.sv =====
module psar_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/psar_rsp_reg.sv =====
module psar_rsp_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  psar_pkg::rsp_load_type load,
   output logic                  slot_free,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output psar_pkg::rsp_type     rsp
);
   import psar_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;
   rsp_type data_in;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      priority if (load.load) begin
         valid_in = 1'b1;
         data_in  = load.item;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   // The register can take a new result: it is empty, or its result is being taken now.
   assign slot_free = !valid_ff || rsp_ready;
   assign rsp_valid = valid_ff;
   assign rsp       = data_ff;

endmodule

// ===== sv/psar_ctrl.sv =====
module psar_ctrl #(
   parameter int MAX_MESSAGE = 64,
   parameter int AW          = 6
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  psar_pkg::req_type      req,
   input  logic                   slot_free,
   output psar_pkg::rsp_load_type load,
   output logic                   stage_we,
   output logic [AW-1:0]          stage_waddr,
   output logic [7:0]             stage_wdata,
   input  logic [7:0]             stage_rdata,
   output logic                   asm_we,
   output logic [AW-1:0]          asm_waddr,
   output logic [7:0]             asm_wdata,
   input  logic [7:0]             asm_rdata,
   output logic [AW-1:0]          raddr
);
   import psar_pkg::*;

   localparam int CW = $clog2(MAX_MESSAGE + 2);
   localparam logic [CW-1:0] MAX_C    = CW'(MAX_MESSAGE);
   localparam logic [CW-1:0] POISON_C = CW'(MAX_MESSAGE + 1);
   localparam logic [CW:0]   MAX_W    = (CW + 1)'(MAX_MESSAGE);

   state_type      state_ff, state_in;
   logic [1:0]     code_ff, code_in;
   logic           open_ff, open_in;
   logic [CW-1:0]  wcount_ff, wcount_in;
   logic [CW-1:0]  alen_ff, alen_in;
   logic [CW-1:0]  idx_ff, idx_in;
   logic [CW-1:0]  base_ff, base_in;
   logic [CW-1:0]  run_len_ff, run_len_in;
   logic           src_asm_ff, src_asm_in;

   logic           accept;
   logic [CW-1:0]  idx_nxt;
   logic [CW-1:0]  asm_sum;
   logic [CW-1:0]  seg_len;
   logic [CW:0]    fit_sum;

   function automatic logic [CW-1:0] idx_nxt_w(input logic [CW-1:0] v);
      return v + CW'(1);
   endfunction

   assign accept  = req_valid && req_ready;
   assign idx_nxt = idx_ff + CW'(1);
   assign asm_sum = base_ff + idx_ff;
   assign seg_len = (code_ff == SEG_FIRST) ? '0 : alen_ff;
   assign fit_sum = {1'b0, seg_len} + {1'b0, wcount_ff};

   assign raddr       = idx_ff[AW-1:0];
   assign stage_waddr = wcount_ff[AW-1:0];
   assign stage_wdata = req.data_byte;
   assign asm_waddr   = asm_sum[AW-1:0];
   assign asm_wdata   = stage_rdata;

   always_comb begin
      state_in   = state_ff;
      code_in    = code_ff;
      open_in    = open_ff;
      wcount_in  = wcount_ff;
      alen_in    = alen_ff;
      idx_in     = idx_ff;
      base_in    = base_ff;
      run_len_in = run_len_ff;
      src_asm_in = src_asm_ff;
      req_ready  = 1'b0;
      stage_we   = 1'b0;
      asm_we     = 1'b0;
      load       = '0;

      unique case (state_ff)
         ST_RECV: begin
            req_ready = 1'b1;
            if (accept) begin
               if (req.write_start) begin
                  code_in   = req.data_byte[7:6];
                  wcount_in = '0;
                  open_in   = 1'b1;
               end else if (open_ff) begin
                  if (wcount_ff < MAX_C) begin
                     stage_we  = 1'b1;
                     wcount_in = idx_nxt_w(wcount_ff);
                  end else begin
                     wcount_in = POISON_C;
                  end
               end
               if (req.write_end && (req.write_start || open_ff)) begin
                  open_in  = 1'b0;
                  state_in = ST_FINISH;
               end
            end
         end

         ST_FINISH: begin
            idx_in = '0;
            if (code_ff == SEG_COMPLETE) begin
               src_asm_in = 1'b0;
               run_len_in = wcount_ff;
               if (wcount_ff == '0) begin
                  state_in = ST_EMPTY;
               end else if (wcount_ff <= MAX_C) begin
                  state_in = ST_EMIT_RD;
               end else begin
                  state_in = ST_RECV;
               end
            end else if (fit_sum <= MAX_W) begin
               base_in  = seg_len;
               state_in = (wcount_ff == '0) ? ST_COPY_DONE : ST_COPY_RD;
            end else begin
               // Overflow poisons the assembly; a last segment just clears it.
               alen_in  = (code_ff == SEG_LAST) ? '0 : POISON_C;
               state_in = ST_RECV;
            end
         end

         ST_COPY_RD: begin
            state_in = ST_COPY_WR;
         end

         ST_COPY_WR: begin
            asm_we   = 1'b1;
            idx_in   = idx_nxt;
            state_in = (idx_nxt == wcount_ff) ? ST_COPY_DONE : ST_COPY_RD;
         end

         ST_COPY_DONE: begin
            idx_in = '0;
            if (code_ff == SEG_LAST) begin
               alen_in    = '0;
               src_asm_in = 1'b1;
               run_len_in = base_ff + wcount_ff;
               state_in   = ((base_ff + wcount_ff) == '0) ? ST_EMPTY : ST_EMIT_RD;
            end else begin
               alen_in  = base_ff + wcount_ff;
               state_in = ST_RECV;
            end
         end

         ST_EMIT_RD: begin
            if (slot_free) begin
               state_in = ST_EMIT_LD;
            end
         end

         ST_EMIT_LD: begin
            load.load               = 1'b1;
            load.item.message_byte  = src_asm_ff ? asm_rdata : stage_rdata;
            load.item.byte_position = 6'(idx_ff);
            load.item.message_end   = (idx_nxt == run_len_ff);
            load.item.empty_message = 1'b0;
            idx_in                  = idx_nxt;
            state_in                = (idx_nxt == run_len_ff) ? ST_RECV : ST_EMIT_RD;
         end

         ST_EMPTY: begin
            if (slot_free) begin
               load.load               = 1'b1;
               load.item.message_byte  = '0;
               load.item.byte_position = '0;
               load.item.message_end   = 1'b1;
               load.item.empty_message = 1'b1;
               state_in                = ST_RECV;
            end
         end

         default: begin
            state_in = ST_RECV;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_RECV;
         code_ff   <= SEG_COMPLETE;
         open_ff   <= 1'b0;
         wcount_ff <= '0;
         alen_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         code_ff   <= code_in;
         open_ff   <= open_in;
         wcount_ff <= wcount_in;
         alen_ff   <= alen_in;
      end
      idx_ff     <= idx_in;
      base_ff    <= base_in;
      run_len_ff <= run_len_in;
      src_asm_ff <= src_asm_in;
   end

endmodule

// ===== sv/proxy_sar_reassembler.sv =====
// Channel   Direction  Ports                          Payload
// req       in         req_valid, req_ready, req      data_byte, write_start, write_end
// rsp       out        rsp_valid, rsp_ready, rsp      message_byte, byte_position,
//                                                     message_end, empty_message
//
// Each byte of a write is taken in ST_RECV; the cycle after a write's final byte is
// spent deciding what the write does. A segment is copied into the assembly memory by
// reading each byte from staging and then writing it, and then the assembly length is
// updated; each result of a message run is a memory read, then a load into the result
// register once it has room. The memories have a registered read and the sequencer
// does one step at a time. Reset is synchronous; the memories need no clearing.
// Input is refused until a copy or a message run is over, so a stalled result holds
// up both the rest of the run and the next byte.
module proxy_sar_reassembler #(
   parameter int MAX_MESSAGE = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  psar_pkg::req_type req,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output psar_pkg::rsp_type rsp
);
   import psar_pkg::*;

   localparam int AW = (MAX_MESSAGE > 1) ? $clog2(MAX_MESSAGE) : 1;

   rsp_load_type  load;
   logic          slot_free;
   logic          stage_we;
   logic [AW-1:0] stage_waddr;
   logic [7:0]    stage_wdata;
   logic [7:0]    stage_rdata;
   logic          asm_we;
   logic [AW-1:0] asm_waddr;
   logic [7:0]    asm_wdata;
   logic [7:0]    asm_rdata;
   logic [AW-1:0] raddr;

   // The sequencer owns the write counters, the assembly length and the
   // segmentation code. It never uses read data from a memory in a cycle it
   // writes the same memory, so no forwarding path is needed.
   psar_ctrl #(
      .MAX_MESSAGE (MAX_MESSAGE),
      .AW          (AW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req         (req),
      .slot_free   (slot_free),
      .load        (load),
      .stage_we    (stage_we),
      .stage_waddr (stage_waddr),
      .stage_wdata (stage_wdata),
      .stage_rdata (stage_rdata),
      .asm_we      (asm_we),
      .asm_waddr   (asm_waddr),
      .asm_wdata   (asm_wdata),
      .asm_rdata   (asm_rdata),
      .raddr       (raddr)
   );

   // Staging memory: the payload of the write currently being received.
   psar_ram #(
      .WIDTH (8),
      .DEPTH (MAX_MESSAGE)
   ) u_stage_ram (
      .clock (clock),
      .we    (stage_we),
      .waddr (stage_waddr),
      .wdata (stage_wdata),
      .raddr (raddr),
      .rdata (stage_rdata)
   );

   // Assembly memory: segments appended in order until the last one arrives.
   psar_ram #(
      .WIDTH (8),
      .DEPTH (MAX_MESSAGE)
   ) u_asm_ram (
      .clock (clock),
      .we    (asm_we),
      .waddr (asm_waddr),
      .wdata (asm_wdata),
      .raddr (raddr),
      .rdata (asm_rdata)
   );

   // The result register decouples the run of results from the consumer.
   psar_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .slot_free (slot_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

`ifndef SYNTHESIS
   // A new result must never overwrite one the consumer has not taken.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load.load |-> (!rsp_valid || rsp_ready))
      else $error("result register overwritten while a transaction is pending");

   // Receiving and copying are exclusive phases of the sequencer.
   a_phase_excl: assert property (@(posedge clock) disable iff (reset)
      !(stage_we && asm_we))
      else $error("staging and assembly writes in the same cycle");

   // Appends stay inside the assembly memory.
   a_asm_bound: assert property (@(posedge clock) disable iff (reset)
      asm_we |-> ({1'b0, asm_waddr} < (AW + 1)'(MAX_MESSAGE)))
      else $error("assembly write beyond the message limit");

   // No byte is taken while a message run is being emitted.
   a_no_req_in_emit: assert property (@(posedge clock) disable iff (reset)
      load.load |-> !req_ready)
      else $error("request transaction accepted during a result run");
`endif

endmodule

// ===== test/psar_checker.sv =====
module psar_checker #(
   parameter int MAX_MESSAGE = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  psar_pkg::req_type req,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  psar_pkg::rsp_type rsp,
   output int                mismatch_count,
   output int                pending_count,
   output int                result_count,
   output int                message_count
);
   import psar_pkg::*;

   logic [7:0]  stage_mem [MAX_MESSAGE];
   logic [7:0]  assembly_mem [MAX_MESSAGE];
   int unsigned stage_len;
   int unsigned assembly_len;
   logic [1:0]  seg_code;
   bit          write_open;
   rsp_type     message_bytes_q [$];
   int          errors;
   int          results;
   int          messages;

   // A message of zero bytes still produces one marked result.
   function automatic void queue_message(input bit from_assembly, input int unsigned n);
      rsp_type r;
      if (n == 0) begin
         r.message_byte  = 8'h00;
         r.byte_position = 6'd0;
         r.message_end   = 1'b1;
         r.empty_message = 1'b1;
         message_bytes_q.push_back(r);
      end else begin
         for (int unsigned i = 0; i < n; i++) begin
            r.message_byte  = from_assembly ? assembly_mem[i] : stage_mem[i];
            r.byte_position = 6'(i);
            r.message_end   = (i + 1 == n);
            r.empty_message = 1'b0;
            message_bytes_q.push_back(r);
         end
      end
   endfunction

   function automatic void close_write();
      int unsigned len;
      len = assembly_len;
      if (seg_code == SEG_COMPLETE) begin
         if (stage_len <= MAX_MESSAGE) begin
            queue_message(1'b0, stage_len);
         end
      end else begin
         if (seg_code == SEG_FIRST) begin
            len = 0;
         end
         if (len + stage_len <= MAX_MESSAGE) begin
            for (int unsigned i = 0; i < stage_len; i++) begin
               assembly_mem[len + i] = stage_mem[i];
            end
            len += stage_len;
         end else begin
            // Poisoned until the next first segment, or cleared by a last one.
            len = MAX_MESSAGE + 1;
         end
         if (seg_code == SEG_LAST) begin
            if (len <= MAX_MESSAGE) begin
               queue_message(1'b1, len);
            end
            len = 0;
         end
         assembly_len = len;
      end
   endfunction

   function automatic void take_byte(input req_type t);
      if (t.write_start) begin
         seg_code   = t.data_byte[7:6];
         stage_len  = 0;
         write_open = 1'b1;
      end else if (!write_open) begin
         return;
      end else if (stage_len < MAX_MESSAGE) begin
         stage_mem[stage_len] = t.data_byte;
         stage_len++;
      end else begin
         stage_len = MAX_MESSAGE + 1;
      end
      if (t.write_end) begin
         write_open = 1'b0;
         close_write();
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         stage_len    = 0;
         assembly_len = 0;
         seg_code     = SEG_COMPLETE;
         write_open   = 1'b0;
         message_bytes_q.delete();
         errors       = 0;
         results      = 0;
         messages     = 0;
      end else begin
         if (req_valid && req_ready) begin
            take_byte(req);
         end
         if (rsp_valid && rsp_ready) begin
            results++;
            if (rsp.message_end) begin
               messages++;
            end
            if (message_bytes_q.size() == 0) begin
               $error("result transaction with nothing expected: message_byte %0h position %0d",
                      rsp.message_byte, rsp.byte_position);
               errors++;
            end else begin
               want = message_bytes_q.pop_front();
               if (rsp.message_byte !== want.message_byte) begin
                  $error("message_byte: expected %0h, got %0h",
                         want.message_byte, rsp.message_byte);
                  errors++;
               end
               if (rsp.byte_position !== want.byte_position) begin
                  $error("byte_position: expected %0d, got %0d",
                         want.byte_position, rsp.byte_position);
                  errors++;
               end
               if (rsp.message_end !== want.message_end) begin
                  $error("message_end: expected %0b, got %0b",
                         want.message_end, rsp.message_end);
                  errors++;
               end
               if (rsp.empty_message !== want.empty_message) begin
                  $error("empty_message: expected %0b, got %0b",
                         want.empty_message, rsp.empty_message);
                  errors++;
               end
            end
         end
      end
      mismatch_count <= errors;
      pending_count  <= message_bytes_q.size();
      result_count   <= results;
      message_count  <= messages;
   end

endmodule

// ===== test/tb_proxy_sar_reassembler.sv =====
module tb_proxy_sar_reassembler;
   import psar_pkg::*;

   localparam int MAX_MESSAGE = 64;
   // Cycles without any transaction on either channel before the run is declared hung.
   // The deliberate receiver hold-off and a full-length segment copy both fit well inside.
   localparam int STALL_LIMIT = 4000;
   // Length of the deliberate receiver hold-off.
   localparam int HOLD_CYCLES = 500;
   // Settling time after the last expected result; covers a full 64-byte copy and more.
   localparam int TAIL_CYCLES = 300;
   // The random part stops once this many bytes have been accepted in total.
   localparam int ITEM_TARGET = 230;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req       = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp;

   int mismatch_count;
   int pending_count;
   int result_count;
   int message_count;

   int          items_sent   = 0;
   int unsigned steady_items = 0;
   bit          held_off     = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   proxy_sar_reassembler #(
      .MAX_MESSAGE (MAX_MESSAGE)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   psar_checker #(
      .MAX_MESSAGE (MAX_MESSAGE)
   ) i_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req            (req),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp            (rsp),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .result_count   (result_count),
      .message_count  (message_count)
   );

   // Offers one byte and holds it until the block takes it. Afterwards the sender may
   // idle: usually not at all, sometimes for a few cycles and now and then for a long
   // stretch. Occasionally a run of forty-one bytes goes out back to back. Valid is only
   // lowered when a gap actually follows, so a back-to-back byte never sees valid
   // dropped and raised in the same step.
   task automatic put(input logic [7:0] b, input logic s, input logic e);
      int unsigned g;
      int unsigned roll;
      req       <= '{data_byte: b, write_start: s, write_end: e};
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      roll = $urandom_range(0, 99);
      if (steady_items > 0) begin
         steady_items--;
         g = 0;
      end else if (roll < 2) begin
         steady_items = 40;
         g = 0;
      end else if (roll < 62) begin
         g = 0;
      end else if (roll < 95) begin
         g = $urandom_range(1, 3);
      end else begin
         g = $urandom_range(10, 30);
      end
      if (g != 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   // Sends one write: a header byte carrying the segmentation code in its top bits and
   // random type bits below, then n random payload bytes. When finish is clear the
   // write is left open, so whatever start comes next abandons it.
   task automatic send_write(input logic [1:0] code, input int unsigned n, input bit finish);
      logic [7:0] hdr;
      hdr = {code, 6'($urandom_range(0, 63))};
      put(hdr, 1'b1, finish && (n == 0));
      for (int unsigned i = 0; i < n; i++) begin
         put(8'($urandom_range(0, 255)), 1'b0, finish && (i + 1 == n));
      end
   endtask

   function automatic int unsigned short_len();
      return $urandom_range(0, 6);
   endfunction

   // One random scenario. A few fixed slots at the start carry the cases that need a full
   // store of bytes or more; the rest are mostly well-formed messages of random
   // content with some orphan segments, abandoned writes and loose bytes mixed in.
   task automatic run_scenario(input int unsigned k);
      int unsigned pick;
      int unsigned parts;
      pick  = $urandom_range(0, 19);
      parts = $urandom_range(0, 3);
      if (k == 0) begin
         // The second segment overruns the store. A middle keeps the assembly poisoned,
         // and the poisoned last emits nothing and clears it; a fresh first and last
         // then emit normally.
         send_write(SEG_FIRST, 33, 1'b1);
         send_write(SEG_MIDDLE, 32, 1'b1);
         send_write(SEG_MIDDLE, short_len(), 1'b1);
         send_write(SEG_LAST, short_len(), 1'b1);
         send_write(SEG_FIRST, short_len(), 1'b1);
         send_write(SEG_LAST, short_len(), 1'b1);
      end else if (k == 1) begin
         // A complete write that is too long is dropped, and its staging count saturates.
         send_write(SEG_COMPLETE, $urandom_range(65, 68), 1'b1);
      end else if (k == 2) begin
         // A complete write of exactly the largest size gives the longest message run.
         send_write(SEG_COMPLETE, MAX_MESSAGE, 1'b1);
      end else if (pick < 6) begin
         send_write(SEG_COMPLETE, short_len(), 1'b1);
      end else if (pick < 13) begin
         send_write(SEG_FIRST, short_len(), 1'b1);
         repeat (parts) send_write(SEG_MIDDLE, short_len(), 1'b1);
         send_write(SEG_LAST, short_len(), 1'b1);
      end else if (pick < 15) begin
         send_write($urandom_range(0, 1) ? SEG_MIDDLE : SEG_LAST, short_len(), 1'b1);
      end else if (pick < 17) begin
         send_write(2'($urandom_range(0, 3)), short_len(), 1'b0);
      end else if (pick < 19) begin
         // Loose bytes: ignored unless an abandoned write is still open to take them.
         repeat (parts + 1) put(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
      end else begin
         send_write(SEG_FIRST, 0, 1'b1);
         send_write(SEG_LAST, 0, 1'b1);
      end
   endtask

   // Receiver side. Ready alternates between high runs and low gaps of random length,
   // with the odd long high run where nothing idles. Once, after the first sixty bytes,
   // ready stays low for a long hold-off while the sender keeps offering bytes, so the
   // block has to fill up and push back on its input.
   initial begin
      int unsigned run;
      int unsigned gap;
      int unsigned roll;
      while (reset) @(posedge clock);
      forever begin
         roll = $urandom_range(0, 99);
         if (roll < 70) begin
            run = $urandom_range(1, 8);
         end else if (roll < 90) begin
            run = $urandom_range(9, 40);
         end else begin
            run = $urandom_range(60, 120);
         end
         gap = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(15, 40);
         rsp_ready <= 1'b1;
         repeat (run) @(posedge clock);
         rsp_ready <= 1'b0;
         if (!held_off && items_sent >= 60) begin
            held_off = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            repeat (gap) @(posedge clock);
         end
      end
   end

   // Watchdog: any transaction on either channel restarts the count.
   initial begin
      int idle_run;
      idle_run = 0;
      while (idle_run < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_run = 0;
         end else begin
            idle_run++;
         end
      end
      $display("tb_proxy_sar_reassembler: errors");
      $finish;
   end

   initial begin
      int unsigned k;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part. A header-only complete write with all type bits set gives the
      // empty result; then a complete write carrying the byte extremes.
      put(8'h3F, 1'b1, 1'b1);
      put(8'h00, 1'b1, 1'b0);
      put(8'h00, 1'b0, 1'b0);
      put(8'hFF, 1'b0, 1'b1);
      // Bytes with no write open are ignored, with or without an end mark.
      put(8'hA5, 1'b0, 1'b1);
      put(8'h5A, 1'b0, 1'b0);
      // First, middle and last segments of one byte each assemble a three-byte message.
      put(8'h41, 1'b1, 1'b0);
      put(8'h12, 1'b0, 1'b1);
      put(8'h80, 1'b1, 1'b0);
      put(8'h34, 1'b0, 1'b1);
      put(8'hC0, 1'b1, 1'b0);
      put(8'h56, 1'b0, 1'b1);
      // A start while a first segment is still open abandons it for a complete write.
      put(8'h40, 1'b1, 1'b0);
      put(8'h77, 1'b0, 1'b0);
      put(8'h00, 1'b1, 1'b0);
      put(8'h99, 1'b0, 1'b1);
      // Header-only first and last segments give an empty assembled message.
      put(8'h7F, 1'b1, 1'b1);
      put(8'hFF, 1'b1, 1'b1);
      // A middle with no first appends to the cleared assembly, and a header-only last
      // emits that single byte.
      put(8'h80, 1'b1, 1'b0);
      put(8'hEE, 1'b0, 1'b1);
      put(8'hC0, 1'b1, 1'b1);

      k = 0;
      while (items_sent < ITEM_TARGET) begin
         run_scenario(k);
         k++;
      end
      req_valid <= 1'b0;

      // One edge first so that the checker's count reflects the final byte.
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d bytes in %0d scenarios; checked %0d result transactions",
               items_sent, k, result_count);
      $display("forming %0d messages, including overruns, drops and a long receiver hold-off.",
               message_count);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("tb_proxy_sar_reassembler: clean");
      end else begin
         $display("tb_proxy_sar_reassembler: errors");
      end
      $finish;
   end

endmodule
